@@ rtl/sjf_pkg.sv @@
// shared constants and types of the shortest-job-first scheduler
package sjf_pkg;

  localparam int MAX_JOBS = 16;
  localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);

  localparam int TAG_W  = 8;
  localparam int TIME_W = 16;
  localparam int CLK_W  = 23;
  localparam int WT_W   = 31;
  localparam int FRAC_W = 8;
  localparam int STEP_W = $clog2(WT_W + 1);

  // one scheduled job, handed from the picker to the divider
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [CLK_W-1:0]  finish;
    logic [CLK_W-1:0]  turn;
    logic [TIME_W-1:0] svc;
    logic              last;
  } job_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

@@ rtl/sjf_fifo.sv @@
// two-entry queue between the job picker and the divider
module sjf_fifo
  import sjf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  job_rec_t   push_rec,
  input  logic       pop,
  output job_rec_t   pop_rec,
  output fifo_stat_t stat
);

  job_rec_t   mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;

  assign stat.full  = (fill_r == 2'd2);
  assign stat.empty = (fill_r == 2'd0);
  assign pop_rec    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> !stat.full)
    else $error("push into full queue");

endmodule

@@ rtl/sjf_front.sv @@
// job table loader and shortest-job picker
module sjf_front
  import sjf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [TAG_W-1:0]  job_tag,
  input  logic [TIME_W-1:0] arrival,
  input  logic [TIME_W-1:0] service,
  input  logic              final_job,
  output logic              push,
  output job_rec_t          push_rec,
  input  fifo_stat_t        q_stat
);

  typedef enum logic [3:0] {
    F_LOAD  = 4'b0001,
    F_EARLY = 4'b0010,
    F_PICK  = 4'b0100,
    F_PUSH  = 4'b1000
  } fstate_t;

  fstate_t state_r, state_nxt;

  logic [TAG_W-1:0]  tag_tab [MAX_JOBS];
  logic [TIME_W-1:0] arr_tab [MAX_JOBS];
  logic [TIME_W-1:0] svc_tab [MAX_JOBS];
  logic [MAX_JOBS-1:0] fin_r, fin_nxt;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  rounds_r, rounds_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [CLK_W-1:0]  clock_r, clock_nxt;
  logic [TIME_W-1:0] early_r, early_nxt;
  logic              efound_r, efound_nxt;
  logic              bfound_r, bfound_nxt;
  logic [IDX_W-1:0]  bidx_r, bidx_nxt;
  logic [TAG_W-1:0]  btag_r, btag_nxt;
  logic [TIME_W-1:0] barr_r, barr_nxt;
  logic [TIME_W-1:0] bsvc_r, bsvc_nxt;

  logic              accept, store, scan_end, cand, better;
  logic [TIME_W-1:0] rd_arr, rd_svc;
  logic [CLK_W-1:0]  finish;

  assign in_ready = (state_r == F_LOAD);
  assign accept   = in_valid && in_ready;
  assign store    = accept && (cnt_r < CNT_W'(MAX_JOBS));
  assign scan_end = (CNT_W'(idx_r) == cnt_r - CNT_W'(1));
  assign rd_arr   = arr_tab[idx_r];
  assign rd_svc   = svc_tab[idx_r];
  assign cand     = !fin_r[idx_r] && (CLK_W'(rd_arr) <= clock_r);
  assign better   = !bfound_r || (rd_svc < bsvc_r) ||
                    ((rd_svc == bsvc_r) && (rd_arr < barr_r));
  assign finish   = clock_r + CLK_W'(bsvc_r);

  assign push          = (state_r == F_PUSH) && !q_stat.full;
  assign push_rec.tag    = btag_r;
  assign push_rec.finish = finish;
  assign push_rec.turn   = finish - CLK_W'(barr_r);
  assign push_rec.svc    = bsvc_r;
  assign push_rec.last   = (rounds_r == cnt_r - CNT_W'(1));

  always_comb begin
    state_nxt  = state_r;
    fin_nxt    = fin_r;
    cnt_nxt    = cnt_r;
    rounds_nxt = rounds_r;
    idx_nxt    = idx_r;
    clock_nxt  = clock_r;
    early_nxt  = early_r;
    efound_nxt = efound_r;
    bfound_nxt = bfound_r;
    bidx_nxt   = bidx_r;
    btag_nxt   = btag_r;
    barr_nxt   = barr_r;
    bsvc_nxt   = bsvc_r;
    unique case (state_r)
      F_LOAD: begin
        if (store) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        if (accept && final_job) begin
          state_nxt  = F_EARLY;
          idx_nxt    = '0;
          efound_nxt = 1'b0;
          rounds_nxt = '0;
          clock_nxt  = '0;
        end
      end
      F_EARLY: begin
        if (!fin_r[idx_r] && (!efound_r || rd_arr < early_r)) begin
          early_nxt  = rd_arr;
          efound_nxt = 1'b1;
        end
        idx_nxt = idx_r + IDX_W'(1);
        if (scan_end) begin
          // idle clock jumps to the earliest waiting arrival
          if (!fin_r[idx_r] && (!efound_r || rd_arr < early_r)) begin
            if (CLK_W'(rd_arr) > clock_r) clock_nxt = CLK_W'(rd_arr);
          end else if (efound_r && CLK_W'(early_r) > clock_r) begin
            clock_nxt = CLK_W'(early_r);
          end
          state_nxt  = F_PICK;
          idx_nxt    = '0;
          bfound_nxt = 1'b0;
        end
      end
      F_PICK: begin
        if (cand && better) begin
          bfound_nxt = 1'b1;
          bidx_nxt   = idx_r;
          btag_nxt   = tag_tab[idx_r];
          barr_nxt   = rd_arr;
          bsvc_nxt   = rd_svc;
        end
        idx_nxt = idx_r + IDX_W'(1);
        if (scan_end) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_stat.full) begin
          clock_nxt        = finish;
          fin_nxt[bidx_r]  = 1'b1;
          rounds_nxt       = rounds_r + CNT_W'(1);
          idx_nxt          = '0;
          efound_nxt       = 1'b0;
          if (push_rec.last) begin
            state_nxt = F_LOAD;
            cnt_nxt   = '0;
            fin_nxt   = '0;
            clock_nxt = '0;
          end else begin
            state_nxt = F_EARLY;
          end
        end
      end
      default: state_nxt = F_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (store) begin
      tag_tab[cnt_r[IDX_W-1:0]] <= job_tag;
      arr_tab[cnt_r[IDX_W-1:0]] <= arrival;
      svc_tab[cnt_r[IDX_W-1:0]] <= service;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_LOAD;
      fin_r    <= '0;
      cnt_r    <= '0;
      rounds_r <= '0;
      idx_r    <= '0;
      clock_r  <= '0;
      efound_r <= 1'b0;
      bfound_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fin_r    <= fin_nxt;
      cnt_r    <= cnt_nxt;
      rounds_r <= rounds_nxt;
      idx_r    <= idx_nxt;
      clock_r  <= clock_nxt;
      efound_r <= efound_nxt;
      bfound_r <= bfound_nxt;
    end
  end

  always_ff @(posedge clk) begin
    early_r <= early_nxt;
    bidx_r  <= bidx_nxt;
    btag_r  <= btag_nxt;
    barr_r  <= barr_nxt;
    bsvc_r  <= bsvc_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_JOBS))
    else $error("job count beyond table");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == F_EARLY || state_r == F_PICK) |-> cnt_r != '0)
    else $error("scan with empty table");

  a_batch_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_rec.last) |=> (cnt_r == '0 && fin_r == '0))
    else $error("batch not cleared");

  a_pick_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == F_PUSH) |-> bfound_r)
    else $error("no job picked");

endmodule

@@ rtl/sjf_div.sv @@
// serial divider for weighted turnaround and result register
module sjf_div
  import sjf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  fifo_stat_t q_stat,
  output logic       pop,
  input  job_rec_t   pop_rec,
  output logic       out_valid,
  input  logic       out_ready,
  output job_rec_t   res_rec,
  output logic [WT_W-1:0] res_wt
);

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_RUN  = 3'b010,
    D_OUT  = 3'b100
  } dstate_t;

  dstate_t state_r, state_nxt;
  job_rec_t rec_r;
  logic [WT_W-1:0]   dq_r, dq_nxt;
  logic [TIME_W-1:0] rem_r, rem_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [TIME_W:0]   trial;
  logic              qbit;

  assign pop       = (state_r == D_IDLE) && !q_stat.empty;
  assign out_valid = (state_r == D_OUT);
  assign res_rec   = rec_r;
  assign res_wt    = dq_r;

  // restoring step, one quotient bit per cycle; zero divisor gives all ones
  assign trial = {rem_r, dq_r[WT_W-1]};
  assign qbit  = (trial >= {1'b0, rec_r.svc});

  always_comb begin
    state_nxt = state_r;
    dq_nxt    = dq_r;
    rem_nxt   = rem_r;
    step_nxt  = step_r;
    unique case (state_r)
      D_IDLE: begin
        if (pop) begin
          state_nxt = D_RUN;
          dq_nxt    = {pop_rec.turn, FRAC_W'(0)};
          rem_nxt   = '0;
          step_nxt  = STEP_W'(WT_W);
        end
      end
      D_RUN: begin
        rem_nxt  = qbit ? TIME_W'(trial - {1'b0, rec_r.svc}) : trial[TIME_W-1:0];
        dq_nxt   = {dq_r[WT_W-2:0], qbit};
        step_nxt = step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) state_nxt = D_OUT;
      end
      D_OUT: begin
        if (out_ready) state_nxt = D_IDLE;
      end
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) rec_r <= pop_rec;
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  a_run_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == D_RUN) |-> step_r != '0)
    else $error("divider ran out of steps");

endmodule

@@ rtl/sjf_job_scheduler.sv @@
// top level of the non-preemptive shortest-job-first scheduler
//
// Jobs stream in one beat each (tag, arrival, service) into a table of
// MAX_JOBS entries; a beat with tlast set closes the batch, and jobs beyond
// a full table are dropped. The scheduler then runs from time zero: each
// round it picks the shortest arrived, unfinished job (ties to earlier
// arrival, then load order), jumping the clock to the next arrival when
// nothing is waiting, and emits one result beat per job in completion
// order, tlast on the last of the batch. Weighted turnaround is
// turnaround*256/service, truncated; zero service gives all ones. The
// table loads one beat per cycle while the front is in its load state. Per
// scheduled job the picker makes two passes over the n-entry table plus a
// hand-off, and the divider does 31 one-bit steps plus load and result. A
// two-entry queue sits between picker and divider, and a new batch may
// load while earlier results are still being divided or wait to be taken.
module sjf_job_scheduler
  import sjf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // job_tag[7:0], arrival[23:8], service[39:24]
  input  logic        in_tlast,   // final_job
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // done_tag, finish_time, turnaround,
                                  // weighted_turnaround, zero pad
  output logic        out_tlast   // last_result
);

  logic       push, pop;
  job_rec_t   push_rec, pop_rec, res_rec;
  fifo_stat_t q_stat;
  logic [WT_W-1:0] res_wt;

  // front: table load and shortest-job pick
  sjf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .job_tag   (in_tdata[7:0]),
    .arrival   (in_tdata[23:8]),
    .service   (in_tdata[39:24]),
    .final_job (in_tlast),
    .push      (push),
    .push_rec  (push_rec),
    .q_stat    (q_stat)
  );

  // decoupling queue
  sjf_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .pop_rec  (pop_rec),
    .stat     (q_stat)
  );

  // back: weighted turnaround division and output register
  sjf_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop       (pop),
    .pop_rec   (pop_rec),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res_rec   (res_rec),
    .res_wt    (res_wt)
  );

  assign out_tdata = {3'b000, res_wt, res_rec.turn, res_rec.finish, res_rec.tag};
  assign out_tlast = res_rec.last;

endmodule

@@ bench/tb_sjf_job_scheduler.sv @@
// self-checking testbench for the shortest-job-first scheduler
`timescale 1ns / 100ps

module tb_sjf_job_scheduler;
  import sjf_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  // one job beat as loaded
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] service;
    logic              final_job;
  } job_beat_t;

  // one completion beat
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [CLK_W-1:0] finish;
    logic [CLK_W-1:0] turn;
    logic [WT_W-1:0]  weighted;
    logic             last;
  } done_beat_t;

  // directed row: beat plus an optional typed-in completion
  typedef struct {
    job_beat_t  beat;
    bit         has_known;
    done_beat_t known;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;
  logic        out_tlast;

  sjf_job_scheduler dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state: the batch being loaded
  logic [TAG_W-1:0]  batch_tag [MAX_JOBS];
  logic [TIME_W-1:0] batch_arr [MAX_JOBS];
  logic [TIME_W-1:0] batch_svc [MAX_JOBS];
  int                batch_len = 0;

  done_beat_t completions_due[$];
  int mismatch_count = 0;
  int idle_cycles = 0;
  bit sending_done = 1'b0;
  bit hold_off = 1'b0;

  // load one job and, on the closing beat, schedule the batch
  task automatic schedule_beat(input job_beat_t b);
    bit                done_flag [MAX_JOBS];
    logic [CLK_W-1:0]  now;
    logic [CLK_W-1:0]  turn;
    logic [16:0]       earliest;
    logic [63:0]       wt;
    done_beat_t        d;
    int                best;
    if (batch_len < MAX_JOBS) begin
      batch_tag[batch_len] = b.tag;
      batch_arr[batch_len] = b.arrival;
      batch_svc[batch_len] = b.service;
      batch_len++;
    end
    if (!b.final_job) return;
    foreach (done_flag[i]) done_flag[i] = 1'b0;
    now = '0;
    for (int k = 0; k < batch_len; k++) begin
      earliest = 17'h1ffff;
      for (int i = 0; i < batch_len; i++)
        if (!done_flag[i] && batch_arr[i] < earliest) earliest = 17'(batch_arr[i]);
      if (CLK_W'(earliest) > now) now = CLK_W'(earliest);
      best = -1;
      for (int i = 0; i < batch_len; i++) begin
        if (done_flag[i] || CLK_W'(batch_arr[i]) > now) continue;
        if (best < 0 || batch_svc[i] < batch_svc[best] ||
            (batch_svc[i] == batch_svc[best] && batch_arr[i] < batch_arr[best]))
          best = i;
      end
      now = now + CLK_W'(batch_svc[best]);
      done_flag[best] = 1'b1;
      turn = now - CLK_W'(batch_arr[best]);
      if (batch_svc[best] == 0) wt = {33'b0, {WT_W{1'b1}}};
      else wt = ({41'b0, turn} << FRAC_W) / 64'(batch_svc[best]);
      d.tag = batch_tag[best];
      d.finish = now;
      d.turn = turn;
      d.weighted = wt[WT_W-1:0];
      d.last = (k + 1 == batch_len);
      completions_due.insert(completions_due.size(), d);
    end
    batch_len = 0;
  endtask

  function automatic job_beat_t rand_job(input bit fin, input int span);
    job_beat_t b;
    b.tag = 8'($urandom_range(0, 255));
    b.arrival = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                            : 16'($urandom_range(0, span));
    b.service = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535))
                                            : 16'($urandom_range(1, span));
    b.final_job = fin;
    return b;
  endfunction

  // drive one beat and wait for its handshake
  task automatic send_beat(input job_beat_t b);
    in_tdata <= {b.service, b.arrival, b.tag};
    in_tlast <= b.final_job;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    schedule_beat(b);
  endtask

  // random gap after some beats, so bursts of random length alternate with idle stretches
  task automatic maybe_gap();
    if ($urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // directed table
  dir_row_t dir_rows[$];

  function automatic dir_row_t row(input logic [7:0] tg, input logic [15:0] ar,
                                   input logic [15:0] sv, input bit fin);
    dir_row_t r;
    r.beat = '{tag: tg, arrival: ar, service: sv, final_job: fin};
    r.has_known = 1'b0;
    r.known = '0;
    return r;
  endfunction

  initial begin
    dir_row_t r;
    // single job right after reset: finish = service, turnaround = service
    r = row(8'h00, 16'h0000, 16'h0001, 1'b1);
    r.has_known = 1'b1;
    r.known = '{tag: 8'h00, finish: 23'd1, turn: 23'd1, weighted: 31'd256, last: 1'b1};
    dir_rows.insert(dir_rows.size(), r);
    // extremes: late arrival makes the clock jump, longest service
    r = row(8'hff, 16'hffff, 16'hffff, 1'b1);
    r.has_known = 1'b1;
    r.known = '{tag: 8'hff, finish: 23'h1fffe, turn: 23'hffff, weighted: 31'd256,
                last: 1'b1};
    dir_rows.insert(dir_rows.size(), r);
    // zero service saturates the weighted turnaround
    r = row(8'h5a, 16'h0003, 16'h0000, 1'b1);
    r.has_known = 1'b1;
    r.known = '{tag: 8'h5a, finish: 23'd3, turn: 23'd0, weighted: {WT_W{1'b1}},
                last: 1'b1};
    dir_rows.insert(dir_rows.size(), r);
    // ties on service, then on arrival; shortest wins once arrived
    dir_rows.insert(dir_rows.size(), row(8'h11, 16'd0, 16'd10, 1'b0));
    dir_rows.insert(dir_rows.size(), row(8'h22, 16'd2, 16'd4, 1'b0));
    dir_rows.insert(dir_rows.size(), row(8'h33, 16'd1, 16'd4, 1'b0));
    dir_rows.insert(dir_rows.size(), row(8'h44, 16'd1, 16'd4, 1'b0));
    dir_rows.insert(dir_rows.size(), row(8'h55, 16'd500, 16'd2, 1'b1));
    // full table: seventeen beats, the last dropped but still closing the batch
    for (int i = 0; i < MAX_JOBS; i++)
      dir_rows.insert(dir_rows.size(),
                      row(8'(i + 8'h80), 16'(i * 3), 16'(17 - i), 1'b0));
    dir_rows.insert(dir_rows.size(), row(8'hee, 16'd0, 16'd1, 1'b1));
  end

  // directed expectations typed in are cross-checked against the predictor
  task automatic run_directed();
    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].beat);
      if (dir_rows[i].has_known && completions_due[$] !== dir_rows[i].known) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("directed row %0d: typed-in completion disagrees with predictor", i);
      end
      maybe_gap();
    end
    in_tvalid <= 1'b0;
  endtask

  task automatic run_random();
    int sent;
    int n;
    int span;
    sent = 0;
    while (sent < 95) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 19)
                                      : $urandom_range(1, 8);
      span = ($urandom_range(0, 1) == 0) ? 40 : 2000;
      for (int i = 0; i < n; i++) begin
        send_beat(rand_job(i == n - 1, span));
        sent++;
        maybe_gap();
      end
    end
    in_tvalid <= 1'b0;
  endtask

  // stimulus
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    // long receiver hold-off while batches keep arriving
    hold_off = 1'b1;
    for (int i = 0; i < 12; i++) begin
      send_beat(rand_job(1'b1, 30));
    end
    in_tvalid <= 1'b0;
    hold_off = 1'b0;
    run_random();
    sending_done = 1'b1;
  end

  // receiver: own stall pattern, plus the long hold-off
  initial begin
    int hold;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_tready <= 1'b0;
        for (hold = 0; hold < 600; hold++) @(posedge clk);
        out_tready <= 1'b1;
        wait (!hold_off);
      end else if ($urandom_range(0, 15) < 3) begin
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 63) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(5, 40)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // checker
  always @(posedge clk) begin
    done_beat_t got;
    done_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.tag = out_tdata[7:0];
      got.finish = out_tdata[30:8];
      got.turn = out_tdata[53:31];
      got.weighted = out_tdata[84:54];
      got.last = out_tlast;
      if (completions_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected completion beat: tag %0d finish %0d", got.tag, got.finish);
      end else begin
        want = completions_due.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("completion mismatch: exp tag %0d fin %0d turn %0d wt %0d last %0b, ",
                     want.tag, want.finish, want.turn, want.weighted, want.last,
                     "got tag %0d fin %0d turn %0d wt %0d last %0b",
                     got.tag, got.finish, got.turn, got.weighted, got.last);
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // end of run
  initial begin
    wait (sending_done);
    wait (completions_due.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/sjf_pkg.sv
rtl/sjf_fifo.sv
rtl/sjf_front.sv
rtl/sjf_div.sv
rtl/sjf_job_scheduler.sv
bench/tb_sjf_job_scheduler.sv
